[hdl/bpcb_pkg.sv]
`default_nettype none

package bpcb_pkg;

    // Default width of the wrapping tick counter and its timestamps
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration register widths
    localparam int CFG_TICK_W  = 16;
    localparam int CFG_COUNT_W = 3;
    localparam int CFG_INDEX_W = 3;

    // Result field widths
    localparam int COUNT_W = 3;
    localparam int BLINK_W = 4;

    // Stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CFG_TICK_W-1:0]  DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_TICK_W-1:0]  LONG_RST      = 16'd800;
    localparam logic [CFG_TICK_W-1:0]  INTERVAL_RST  = 16'd200;
    localparam logic [CFG_TICK_W-1:0]  FAST_RST      = 16'd100;
    localparam logic [CFG_COUNT_W-1:0] MAX_COUNT_RST = 3'd5;

    // One result, led_level in the lowest bit
    typedef struct packed {
        logic [BLINK_W-1:0] blinks_left;
        logic [COUNT_W-1:0] press_count;
        logic               long_press;
        logic               pressed;
        logic               led_level;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage : bpcb_pkg

`default_nettype wire

[hdl/button_press_classifier_blinker.sv]
`default_nettype none

// Button press classifier with LED feedback. Each input transaction is one
// millisecond tick carrying the sampled active-low button level in s_tdata[0];
// each tick yields exactly one output transaction with the LED level and the
// press status after that tick. Falling edges toggle the LED when the prior
// edge is older than the debounce time; a debounced hold becomes a press, a
// hold beyond the long-press time blinks the LED at the fast rate, and a short
// release bumps a wrapping press count and then toggles the LED twice that many
// times at the blink interval. All time tests are wrapping subtractions on a
// TIME_WIDTH-bit tick counter. Throughput is one tick per clock: the whole
// tick update is one registered pass over the state registers, and a new tick
// enters in the same cycle that the previous result is taken. While a result
// is held and m_tready is low, s_tready is low. The result is registered and is
// out in the cycle after its tick. Configuration registers are written over the
// cfg_* channel (always ready); the user must write them only while no tick is
// in flight (not enforced by the block); a write past the last index is dropped.

module button_press_classifier_blinker #(
    parameter int TIME_WIDTH = bpcb_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Tick input; s_tdata: [0] button_level, [7:1] zero
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [bpcb_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result; m_tdata: [0] led_level, [1] pressed, [2] long_press,
    // [5:3] press_count, [9:6] blinks_left, [15:10] zero
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [bpcb_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [bpcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bpcb_pkg::CFG_TICK_W-1:0]   cfg_data
);
    import bpcb_pkg::*;

    localparam int PAD_W = TIME_WIDTH - CFG_TICK_W;

    // Configuration registers
    logic [CFG_TICK_W-1:0]  debounce_reg;
    logic [CFG_TICK_W-1:0]  long_reg;
    logic [CFG_TICK_W-1:0]  interval_reg;
    logic [CFG_TICK_W-1:0]  fast_reg;
    logic [CFG_COUNT_W-1:0] max_count_reg;

    // Tick state
    logic [TIME_WIDTH-1:0] tick_reg,        tick_next;
    logic [TIME_WIDTH-1:0] edge_stamp_reg,  edge_stamp_next;
    logic [TIME_WIDTH-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_WIDTH-1:0] blink_stamp_reg, blink_stamp_next;
    logic [COUNT_W-1:0]    count_reg,       count_next;
    logic [BLINK_W-1:0]    blink_left_reg,  blink_left_next;
    logic                  press_reg,       press_next;
    logic                  long_flag_reg,   long_flag_next;
    logic                  led_reg,         led_next;
    logic                  prev_button_reg;

    // Output register
    logic                  m_valid_reg;
    result_t               result_reg, result_next;

    logic                  s_accept;
    logic                  level;
    logic                  fall;
    logic [TIME_WIDTH-1:0] el_edge, el_press, el_blink;
    logic [TIME_WIDTH-1:0] deb_w, long_w, intv_w, fast_w;
    logic                  edge_old;
    logic                  start;
    logic                  held_low;
    logic                  release_evt;
    logic                  short_rel;
    logic                  tog_edge, tog_fast, tog_blink;
    logic                  blink_hit;
    logic [COUNT_W:0]      count_inc;
    logic [COUNT_W-1:0]    count_wrap;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-RESULT_W){1'b0}}, result_reg};

    // Register values on the time axis
    assign deb_w  = {{PAD_W{1'b0}}, debounce_reg};
    assign long_w = {{PAD_W{1'b0}}, long_reg};
    assign intv_w = {{PAD_W{1'b0}}, interval_reg};
    assign fast_w = {{PAD_W{1'b0}}, fast_reg};

    // Elapsed times against the stored stamps, wrapping
    assign el_edge  = tick_reg - edge_stamp_reg;
    assign el_press = tick_reg - press_stamp_reg;
    assign el_blink = tick_reg - blink_stamp_reg;

    always_comb begin
        level    = s_tdata[0];
        fall     = prev_button_reg && !level;
        edge_old = el_edge > deb_w;

        // Edge step: toggle on a debounced falling edge; stamp always
        tog_edge = fall && edge_old;

        // Press detect: an edge this tick restamps, so elapsed is zero then
        start = !level && !press_reg && !fall && edge_old;

        // Long press: a press started this tick cannot be long yet
        held_low = !level && press_reg;
        if (start) begin
            long_flag_next = 1'b0;
        end else if (held_low && (el_press > long_w)) begin
            long_flag_next = 1'b1;
        end else begin
            long_flag_next = long_flag_reg;
        end
        tog_fast = held_low && long_flag_next && (el_blink > fast_w);

        // Release
        release_evt = level && press_reg;
        short_rel   = release_evt && (el_press < long_w);
        count_inc   = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
        if (count_inc > {1'b0, max_count_reg}) begin
            count_wrap = {{(COUNT_W-1){1'b0}}, 1'b1};
        end else begin
            count_wrap = count_inc[COUNT_W-1:0];
        end

        // Blink engine: a stamp taken this tick leaves zero elapsed
        blink_hit = tog_fast || short_rel;
        tog_blink = !blink_hit && (blink_left_reg != '0) && (el_blink > intv_w);

        count_next       = short_rel ? count_wrap : count_reg;
        if (short_rel) begin
            blink_left_next = {count_wrap, 1'b0};
        end else if (tog_blink) begin
            blink_left_next = blink_left_reg - {{(BLINK_W-1){1'b0}}, 1'b1};
        end else begin
            blink_left_next = blink_left_reg;
        end
        blink_stamp_next = (blink_hit || tog_blink) ? tick_reg : blink_stamp_reg;
        edge_stamp_next  = (fall || release_evt) ? tick_reg : edge_stamp_reg;
        press_stamp_next = start ? tick_reg : press_stamp_reg;
        if (start) begin
            press_next = 1'b1;
        end else if (release_evt) begin
            press_next = 1'b0;
        end else begin
            press_next = press_reg;
        end
        led_next  = led_reg ^ tog_edge ^ tog_fast ^ tog_blink;
        tick_next = tick_reg + {{(TIME_WIDTH-1){1'b0}}, 1'b1};

        result_next.led_level   = led_next;
        result_next.pressed     = press_next;
        result_next.long_press  = long_flag_next;
        result_next.press_count = count_next;
        result_next.blinks_left = blink_left_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RST;
            long_reg      <= LONG_RST;
            interval_reg  <= INTERVAL_RST;
            fast_reg      <= FAST_RST;
            max_count_reg <= MAX_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                CFG_LONG:      long_reg      <= cfg_data;
                CFG_INTERVAL:  interval_reg  <= cfg_data;
                CFG_FAST:      fast_reg      <= cfg_data;
                CFG_MAX_COUNT: max_count_reg <= cfg_data[CFG_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick state, advanced once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            edge_stamp_reg  <= '0;
            press_stamp_reg <= '0;
            blink_stamp_reg <= '0;
            count_reg       <= '0;
            blink_left_reg  <= '0;
            press_reg       <= 1'b0;
            long_flag_reg   <= 1'b0;
            led_reg         <= 1'b0;
            prev_button_reg <= 1'b1;
        end else if (s_accept) begin
            tick_reg        <= tick_next;
            edge_stamp_reg  <= edge_stamp_next;
            press_stamp_reg <= press_stamp_next;
            blink_stamp_reg <= blink_stamp_next;
            count_reg       <= count_next;
            blink_left_reg  <= blink_left_next;
            press_reg       <= press_next;
            long_flag_reg   <= long_flag_next;
            led_reg         <= led_next;
            prev_button_reg <= level;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // A new press always starts as a short one
    a_press_clears_long: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(press_reg) |-> !long_flag_reg)
        else $error("press started with long flag set");

    // Pending blinks never exceed twice the largest count
    a_blink_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        blink_left_reg <= 4'd14)
        else $error("blink counter out of range");

    // Every accepted tick produces a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted tick without result");

    // Tick counter moves only with an accepted transaction
    a_tick_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(s_accept) |-> $stable(tick_reg))
        else $error("tick counter moved without a transaction");

endmodule : button_press_classifier_blinker

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bpcb_pkg::*;

    localparam int TW          = TIME_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;  // watchdog limit for the ~2k-tick run
    localparam int TICK_TARGET = 1950;
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CAP    = 120;     // keeps holds and gaps short under huge timings

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [0] button_level, rest zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [0] led, [1] pressed, [2] long, [5:3] count, [9:6] blinks
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_TICK_W-1:0]  cfg_data;

    button_press_classifier_blinker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the classifier: configuration and tick state
    // ------------------------------------------------------------------
    logic [CFG_TICK_W-1:0]  debounce_cfg;
    logic [CFG_TICK_W-1:0]  long_cfg;
    logic [CFG_TICK_W-1:0]  interval_cfg;
    logic [CFG_TICK_W-1:0]  fast_cfg;
    logic [CFG_COUNT_W-1:0] max_cfg;

    logic [TW-1:0]          tick_ctr;
    logic [TW-1:0]          last_edge;
    logic [TW-1:0]          press_t0;
    logic [TW-1:0]          last_blink;
    logic [COUNT_W-1:0]     count_q;
    logic [BLINK_W-1:0]     blinks_q;
    logic                   press_q;
    logic                   long_q;
    logic                   led_q;
    logic                   btn_prev;

    // Expected LED/status words, oldest first
    result_t                pending_results[$];

    logic                   idle_on;
    int unsigned            ticks_sent;
    int unsigned            errors;
    int unsigned            settings_used;
    int unsigned            short_releases;
    int unsigned            long_releases;
    int unsigned            count_wraps;
    int unsigned            cycles;

    function automatic logic [TW-1:0] elapsed(input logic [TW-1:0] now, stamp);
        return now - stamp;  // wraps modulo 2^TW
    endfunction

    task automatic reset_shadow;
        debounce_cfg = DEBOUNCE_RST;
        long_cfg     = LONG_RST;
        interval_cfg = INTERVAL_RST;
        fast_cfg     = FAST_RST;
        max_cfg      = MAX_COUNT_RST;
        tick_ctr     = '0;
        last_edge    = '0;
        press_t0     = '0;
        last_blink   = '0;
        count_q      = '0;
        blinks_q     = '0;
        press_q      = 1'b0;
        long_q       = 1'b0;
        led_q        = 1'b0;
        btn_prev     = 1'b1;  // released
    endtask

    // One millisecond tick: edge, press detect, long press, release, blink engine
    task automatic advance_tick(input logic level, output result_t r);
        logic [TW-1:0]    now;
        logic [COUNT_W:0] nxt;
        now = tick_ctr;
        // falling edge toggles only when the previous edge is old enough
        if (btn_prev && !level) begin
            if (elapsed(now, last_edge) > debounce_cfg)
                led_q = ~led_q;
            last_edge = now;
        end
        if (!level && !press_q && elapsed(now, last_edge) > debounce_cfg) begin
            press_q  = 1'b1;
            press_t0 = now;
            long_q   = 1'b0;
        end
        if (press_q && !level) begin
            if (elapsed(now, press_t0) > long_cfg)
                long_q = 1'b1;
            if (long_q && elapsed(now, last_blink) > fast_cfg) begin
                led_q      = ~led_q;
                last_blink = now;
            end
        end
        if (level && press_q) begin
            // strictly shorter than the long time counts; long_q stays as is
            if (elapsed(now, press_t0) < long_cfg) begin
                nxt = {1'b0, count_q} + 1'b1;
                if (nxt > {1'b0, max_cfg}) begin
                    nxt = {{COUNT_W{1'b0}}, 1'b1};
                    count_wraps++;
                end
                count_q    = nxt[COUNT_W-1:0];
                blinks_q   = {count_q, 1'b0};
                last_blink = now;
                short_releases++;
            end else begin
                long_releases++;
            end
            press_q   = 1'b0;
            last_edge = now;
        end
        if (blinks_q != 0 && elapsed(now, last_blink) > interval_cfg) begin
            led_q      = ~led_q;
            blinks_q   = blinks_q - 1'b1;
            last_blink = now;
        end
        btn_prev = level;
        tick_ctr = now + 1'b1;

        r.led_level   = led_q;
        r.pressed     = press_q;
        r.long_press  = long_q;
        r.press_count = count_q;
        r.blinks_left = blinks_q;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers; each is entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_tick(input logic level);
        result_t r;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(level);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_tick(level, r);
        pending_results.push_back(r);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and wait until every tick result has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);  // registered output, plus margin
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_TICK_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE:  debounce_cfg = value;
            CFG_LONG:      long_cfg     = value;
            CFG_INTERVAL:  interval_cfg = value;
            CFG_FAST:      fast_cfg     = value;
            CFG_MAX_COUNT: max_cfg      = value[CFG_COUNT_W-1:0];
            default: ;  // past the last register: dropped
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(input logic [CFG_TICK_W-1:0] deb, lng, intv, fst, maxv);
        drain();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        write_reg(CFG_INTERVAL, intv);
        write_reg(CFG_FAST, fst);
        write_reg(CFG_MAX_COUNT, maxv);
        settings_used++;
    endtask

    task automatic press_release(input int unsigned hold, input int unsigned gap);
        repeat (hold) send_tick(1'b0);
        repeat (gap) send_tick(1'b1);
    endtask

    // One random gesture, sized against the current timings
    task automatic random_gesture;
        int unsigned kind;
        int unsigned hold;
        int unsigned gap;
        kind = $urandom_range(99);
        if (kind < 15) begin
            // raw noise on the pin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
        end else begin
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(1)));
            case ($urandom_range(2))
                0: hold = debounce_cfg + 1 + $urandom_range(long_cfg);
                1: hold = debounce_cfg + long_cfg + 2 + $urandom_range(4 * (fast_cfg + 1));
                default: hold = debounce_cfg + long_cfg + $urandom_range(3);
            endcase
            gap = $urandom_range(16 * (interval_cfg + 1));
            if (hold > HOLD_CAP) hold = HOLD_CAP;
            if (gap > HOLD_CAP) gap = HOLD_CAP;
            press_release(hold, gap);
        end
    endtask

    task automatic run_gestures(input int unsigned n_ticks);
        int unsigned stop_at;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) random_gesture();
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Reset timings: a bounce right after reset must not toggle or press
    task automatic test_defaults;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Fast timings: clean short press, then a bounce inside the debounce window
    task automatic test_short_and_bounce;
        write_all(16'd2, 16'd6, 16'd1, 16'd1, 16'd7);
        press_release(4, 1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Hold past the long time (fast blinking, long release keeps the count),
    // then a release exactly at the long time, which is neither short nor long
    task automatic test_long_press;
        press_release(12, 2);
        press_release(9, 2);
    endtask

    // Count wrap, maximum lowered under the count, zero maximum, masked writes,
    // and writes past the last register
    task automatic test_count_wrap;
        int i;
        press_release(4, 1);
        press_release(4, 1);
        drain();
        write_reg(CFG_MAX_COUNT, 16'd2);
        press_release(4, 1);
        drain();
        write_reg(CFG_MAX_COUNT, 16'hFFF8);  // masks to zero
        press_release(4, 1);
        drain();
        for (i = CFG_MAX_COUNT + 1; i < 2 ** CFG_INDEX_W; i++) begin
            write_reg(CFG_INDEX_W'(i), 16'hFFFF);
            write_reg(CFG_INDEX_W'(i), 16'h0000);
        end
        write_reg(CFG_MAX_COUNT, 16'hFFFF);  // masks to 7
        press_release(4, 1);
    endtask

    task automatic test_config_extremes;
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd7);
        run_gestures(60);
        // nothing can pass the debounce time within the run
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (25) send_tick(1'($urandom_range(1)));
        // every press is short and the blink engine never fires
        write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd7);
        run_gestures(60);
    endtask

    task automatic test_random_presses;
        int unsigned phase;
        int unsigned chunk;
        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            write_all(16'($urandom_range(6)), 16'($urandom_range(40)),
                      16'($urandom_range(8)), 16'($urandom_range(6)), 16'($urandom()));
            if ($urandom_range(1))
                write_reg(CFG_INDEX_W'($urandom_range(CFG_MAX_COUNT + 1,
                          2 ** CFG_INDEX_W - 1)), 16'($urandom()));
            chunk = (phase == 2) ? 300 : 200;
            if (chunk > TICK_TARGET - ticks_sent) chunk = TICK_TARGET - ticks_sent;
            idle_on = (phase != 2);  // one long stretch with no gaps or stalls
            run_gestures(chunk);
            idle_on = 1'b1;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the per-field compare
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result transaction with no tick outstanding: %h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("led_level", want.led_level, seen.led_level);
                compare_field("pressed", want.pressed, seen.pressed);
                compare_field("long_press", want.long_press, seen.long_press);
                compare_field("press_count", want.press_count, seen.press_count);
                compare_field("blinks_left", want.blinks_left, seen.blinks_left);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_on        = 1'b1;
        ticks_sent     = 0;
        errors         = 0;
        settings_used  = 0;
        short_releases = 0;
        long_releases  = 0;
        count_wraps    = 0;
        cycles         = 0;
        reset_shadow();

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_defaults();
        test_short_and_bounce();
        test_long_press();
        test_count_wrap();
        test_config_extremes();
        test_random_presses();
        drain();

        $display("%0d ticks over %0d register settings: %0d short releases, %0d long,",
                 ticks_sent, settings_used, short_releases, long_releases);
        $display("%0d press-count wraps, %0d field mismatches", count_wraps, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
